// ----- rtl/cwc_pkg.sv -----
`default_nettype none

package cwc_pkg;

    localparam int DEF_MAX_FRAME      = 4096;
    localparam int DEF_COEF_FRAC_BITS = 16;

    // Phase is an unsigned 32-bit fraction of a full turn.
    localparam int PHASE_BITS         = 32;
    localparam int DIV_BITS_PER_STAGE = 4;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam int HAMMING_A_Q16 = 35389;
    localparam int HAMMING_B_Q16 = 30147;
    localparam int ONE_Q16       = 65536;

    // The accumulator holds the window value exactly in Q47.
    localparam int ACC_W     = 50;
    localparam int ACC_FRAC  = 47;

    typedef enum logic [1:0] {
        KIND_HANN     = 2'd0,
        KIND_HAMMING  = 2'd1,
        KIND_BLACKMAN = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REG_FRAME_LENGTH   = 2'd0,
        REG_WINDOW_KIND    = 2'd1,
        REG_BLACKMAN_ALPHA = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic err;
        logic unit;
    } t_side;

    // Arctangent of 2^-step as a fraction of a full turn, 2^32 per turn.
    function automatic logic signed [CORDIC_W-1:0] cordic_atan(input int step);
        logic signed [CORDIC_W-1:0] a;
        a = '0;
        case (step)
            0:  a = 34'sd536870912;
            1:  a = 34'sd316933406;
            2:  a = 34'sd167458907;
            3:  a = 34'sd85004756;
            4:  a = 34'sd42667331;
            5:  a = 34'sd21354465;
            6:  a = 34'sd10679838;
            7:  a = 34'sd5340245;
            8:  a = 34'sd2670163;
            9:  a = 34'sd1335087;
            10: a = 34'sd667544;
            11: a = 34'sd333772;
            12: a = 34'sd166886;
            13: a = 34'sd83443;
            14: a = 34'sd41722;
            15: a = 34'sd20861;
            16: a = 34'sd10430;
            17: a = 34'sd5215;
            18: a = 34'sd2608;
            19: a = 34'sd1304;
            20: a = 34'sd652;
            21: a = 34'sd326;
            22: a = 34'sd163;
            23: a = 34'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cwc_phase_div.sv -----
`default_nettype none

module cwc_phase_div
    import cwc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [11:0] i_index,
    input  wire logic [12:0] i_len,
    output logic             o_valid,
    output t_side            o_side,
    output logic [31:0]      o_phase
);

    localparam int STAGES = PHASE_BITS / DIV_BITS_PER_STAGE;

    logic [12:0] w_d;
    logic [31:0] w_h;

    logic        r_v    [0:STAGES];
    t_side       r_side [0:STAGES];
    logic [12:0] r_rem  [0:STAGES];
    logic [31:0] r_q    [0:STAGES];

    // Phase is round(n * 2^32 / d), d = N - 1. The numerator's low word is d/2.
    assign w_d = i_len - 13'd1;
    assign w_h = {20'd0, w_d[12:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    // The integer quotient bit is 1 only for n == d; it wraps out of the phase.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0].err  <= ({1'b0, i_index} >= i_len);
            r_side[0].unit <= (i_len == 13'd1);
            r_rem[0]       <= ({1'b0, i_index} == w_d) ? 13'd0 : {1'b0, i_index};
            r_q[0]         <= '0;
        end
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [12:0] n_rem;
        logic [31:0] n_q;

        always_comb begin
            logic [13:0] t;
            logic [12:0] rem;
            logic [31:0] q;
            rem = r_rem[s];
            q   = r_q[s];
            for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
                t = {rem, w_h[PHASE_BITS - 1 - s * DIV_BITS_PER_STAGE - j]};
                if (t >= {1'b0, w_d}) begin
                    t = t - {1'b0, w_d};
                    q = {q[30:0], 1'b1};
                end else begin
                    q = {q[30:0], 1'b0};
                end
                rem = t[12:0];
            end
            n_rem = rem;
            n_q   = q;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s+1] <= r_side[s];
                r_rem[s+1]  <= n_rem;
                r_q[s+1]    <= n_q;
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_side  = r_side[STAGES];
    assign o_phase = r_q[STAGES];

endmodule

`default_nettype wire

// ----- rtl/cwc_cordic.sv -----
`default_nettype none

module cwc_cordic
    import cwc_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire t_side                      i_side,
    input  wire logic [31:0]                i_phase [2],
    output logic                            o_valid,
    output t_side                           o_side,
    output logic signed [CORDIC_W-1:0]      o_cos   [2]
);

    logic  r_v    [0:CORDIC_STEPS];
    t_side r_side [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[i+1] <= r_side[i];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [CORDIC_W-1:0] r_x    [0:CORDIC_STEPS];
        logic signed [CORDIC_W-1:0] r_y    [0:CORDIC_STEPS];
        logic signed [CORDIC_W-1:0] r_z    [0:CORDIC_STEPS];
        logic                       r_flip [0:CORDIC_STEPS];
        logic [31:0]                w_sum;
        logic [31:0]                w_ph;
        logic                       w_flip;

        // Angles in the left half plane are turned by half a turn; the cosine
        // then changes sign.
        always_comb begin
            w_sum  = i_phase[l] + 32'h4000_0000;
            w_flip = w_sum[31];
            w_ph   = w_flip ? (i_phase[l] + 32'h8000_0000) : i_phase[l];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[0]    <= CORDIC_GAIN_Q30;
                r_y[0]    <= '0;
                r_z[0]    <= CORDIC_W'($signed(w_ph));
                r_flip[0] <= w_flip;
            end
        end

        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
            logic signed [CORDIC_W-1:0] w_dx;
            logic signed [CORDIC_W-1:0] w_dy;

            assign w_dx = r_y[i] >>> i;
            assign w_dy = r_x[i] >>> i;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_z[i][CORDIC_W-1]) begin
                        r_x[i+1] <= r_x[i] - w_dx;
                        r_y[i+1] <= r_y[i] + w_dy;
                        r_z[i+1] <= r_z[i] - cordic_atan(i);
                    end else begin
                        r_x[i+1] <= r_x[i] + w_dx;
                        r_y[i+1] <= r_y[i] - w_dy;
                        r_z[i+1] <= r_z[i] + cordic_atan(i);
                    end
                    r_flip[i+1] <= r_flip[i];
                end
            end
        end

        assign o_cos[l] = r_flip[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
    end

    assign o_valid = r_v[CORDIC_STEPS];
    assign o_side  = r_side[CORDIC_STEPS];

endmodule

`default_nettype wire

// ----- rtl/cwc_combine.sv -----
`default_nettype none

module cwc_combine
    import cwc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    parameter int COEF_W         = COEF_FRAC_BITS + 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire t_side                      i_side,
    input  wire logic signed [CORDIC_W-1:0] i_cos [2],
    input  wire t_kind                      i_kind,
    input  wire logic [15:0]                i_alpha,
    output logic                            o_valid,
    output logic [COEF_W-1:0]               o_coef,
    output logic                            o_err
);

    localparam int SH = ACC_FRAC - COEF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ONE_ACC      = ACC_W'(ONE_Q16) <<< 30;
    localparam logic signed [ACC_W-1:0] HAMMING_BIAS = ACC_W'(HAMMING_A_Q16) <<< 31;
    localparam logic signed [ACC_W-1:0] ROUND_HALF   = ACC_W'(1) <<< (SH - 1);
    localparam logic signed [ACC_W-1:0] COEF_ONE     = ACC_W'(1) <<< COEF_FRAC_BITS;

    logic signed [16:0] w_hb;
    logic signed [16:0] w_alpha;
    logic [16:0]        w_alpha_rest;

    logic  r_v [1:4];
    t_side r_side [1:3];

    logic signed [CORDIC_W-1:0] r1_c1;
    logic signed [CORDIC_W-1:0] r1_c2;

    logic signed [ACC_W-1:0]    n2_pb;
    logic signed [ACC_W-1:0]    n2_pa;
    logic signed [ACC_W-1:0]    r2_pb;
    logic signed [ACC_W-1:0]    r2_pa;
    logic signed [CORDIC_W-1:0] r2_c1;

    logic signed [ACC_W-1:0]    w3_c1s;
    logic signed [ACC_W-1:0]    n3_acc;
    logic signed [ACC_W-1:0]    r3_acc;

    logic signed [ACC_W-1:0]    w4_round;
    logic [COEF_W-1:0]          n4_coef;
    logic [COEF_W-1:0]          r4_coef;
    logic                       r4_err;

    assign w_hb         = 17'(HAMMING_B_Q16);
    assign w_alpha      = $signed({1'b0, i_alpha});
    assign w_alpha_rest = 17'(ONE_Q16) - {1'b0, i_alpha};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[1] <= 1'b0;
            r_v[2] <= 1'b0;
            r_v[3] <= 1'b0;
            r_v[4] <= 1'b0;
        end else if (i_en) begin
            r_v[1] <= i_valid;
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3];
        end
    end

    assign n2_pb = r1_c1 * w_hb;
    assign n2_pa = r1_c2 * w_alpha;

    assign w3_c1s = ACC_W'(r2_c1) <<< 16;

    always_comb begin
        unique case (i_kind)
            KIND_HAMMING: begin
                n3_acc = HAMMING_BIAS - (r2_pb <<< 1);
            end
            KIND_BLACKMAN: begin
                n3_acc = ((ACC_W'({33'd0, w_alpha_rest})) <<< 30) - w3_c1s + r2_pa;
            end
            default: begin
                n3_acc = ONE_ACC - w3_c1s;
            end
        endcase
    end

    // Round half up at the output's fraction bits, clamp to +-1.0, zero on err, one if unit.
    always_comb begin
        w4_round = (r3_acc + ROUND_HALF) >>> SH;
        if (r_side[3].err) begin
            n4_coef = '0;
        end else if (r_side[3].unit || (w4_round > COEF_ONE)) begin
            n4_coef = COEF_W'(COEF_ONE);
        end else if (w4_round < -COEF_ONE) begin
            n4_coef = COEF_W'(-COEF_ONE);
        end else begin
            n4_coef = COEF_W'(w4_round);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_c1     <= i_cos[0];
            r1_c2     <= i_cos[1];
            r_side[1] <= i_side;
            r2_pb     <= n2_pb;
            r2_pa     <= n2_pa;
            r2_c1     <= r1_c1;
            r_side[2] <= r_side[1];
            r3_acc    <= n3_acc;
            r_side[3] <= r_side[2];
            r4_coef   <= n4_coef;
            r4_err    <= r_side[3].err;
        end
    end

    assign o_valid = r_v[4];
    assign o_coef  = r4_coef;
    assign o_err   = r4_err;

endmodule

`default_nettype wire

// ----- rtl/cwc_skid.sv -----
`default_nettype none

module cwc_skid
    import cwc_pkg::*;
#(
    parameter int COEF_W = DEF_COEF_FRAC_BITS + 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [COEF_W-1:0] i_coef,
    input  wire logic              i_err,
    output logic                   o_ready,
    output logic                   o_valid,
    output logic [COEF_W-1:0]      o_coef,
    output logic                   o_err,
    input  wire logic              i_ready
);

    logic              r_out_v;
    logic [COEF_W-1:0] r_out_coef;
    logic              r_out_err;
    logic              r_skid_v;
    logic [COEF_W-1:0] r_skid_coef;
    logic              r_skid_err;
    logic              w_out_free;

    assign w_out_free = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_free) begin
            r_out_v  <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    // A word that arrives while the output word is held waits in the skid slot.
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_v) begin
                r_out_coef <= r_skid_coef;
                r_out_err  <= r_skid_err;
            end else begin
                r_out_coef <= i_coef;
                r_out_err  <= i_err;
            end
        end else if (i_push) begin
            r_skid_coef <= i_coef;
            r_skid_err  <= i_err;
        end
    end

    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_coef  = r_out_coef;
    assign o_err   = r_out_err;

endmodule

`default_nettype wire

// ----- rtl/cosine_window_coefficient.sv -----
`default_nettype none

// Window coefficient generator for Hann, Hamming and Blackman windows. Each
// input word carries a sample index n; the output word carries the window value
// at n in signed fixed point (2^COEF_FRAC_BITS is 1.0) and an error flag that is
// set, with a zero value, when n is not below the frame length. The block takes
// one word every clock cycle while its skid slot is free. A word passes through
// the bit-by-bit phase divider, the two CORDIC lanes (one rotation per stage),
// the multiply, sum and rounding stages and the output register. The user must
// write configuration through the plain write port only while no word is in
// flight; the block itself does not enforce this.

module cosine_window_coefficient
    import cwc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data,

    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    // [11:0] sample_index, [15:12] zero
    input  wire logic [15:0] s_axis_tdata,

    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    // [COEF_FRAC_BITS+1:0] coefficient, zero above
    output logic [(((COEF_FRAC_BITS + 2) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // [0] index_error
    output logic            m_axis_tuser
);

    localparam int COEF_W   = COEF_FRAC_BITS + 2;
    localparam int TDATA_W  = ((COEF_W + 7) / 8) * 8;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

    logic [12:0] r_frame;
    t_kind       r_kind;
    logic [15:0] r_alpha;

    logic [12:0] w_len;
    logic        w_en;

    logic        w_div_v;
    t_side       w_div_side;
    logic [31:0] w_p1;
    logic [31:0] w_phase [2];

    logic                       w_cor_v;
    t_side                      w_cor_side;
    logic signed [CORDIC_W-1:0] w_cos [2];

    logic              w_cmb_v;
    logic [COEF_W-1:0] w_cmb_coef;
    logic              w_cmb_err;

    logic              w_out_v;
    logic [COEF_W-1:0] w_out_coef;
    logic              w_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= 13'd1024;
            r_kind  <= KIND_HANN;
            r_alpha <= 16'd10486;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_LENGTH:   r_frame <= i_cfg_data[12:0];
                REG_WINDOW_KIND:    r_kind  <= t_kind'(i_cfg_data[1:0]);
                REG_BLACKMAN_ALPHA: r_alpha <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_len = (int'(r_frame) > DEF_MAX_FRAME) ? 13'(DEF_MAX_FRAME) : r_frame;

    // The whole pipeline moves while the skid slot is free.
    assign s_axis_tready = w_en;

    cwc_phase_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_index (s_axis_tdata[11:0]),
        .i_len   (w_len),
        .o_valid (w_div_v),
        .o_side  (w_div_side),
        .o_phase (w_p1)
    );

    assign w_phase[0] = w_p1;
    assign w_phase[1] = {w_p1[30:0], 1'b0};

    cwc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_v),
        .i_side  (w_div_side),
        .i_phase (w_phase),
        .o_valid (w_cor_v),
        .o_side  (w_cor_side),
        .o_cos   (w_cos)
    );

    cwc_combine #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .COEF_W         (COEF_W)
    ) u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cor_v),
        .i_side  (w_cor_side),
        .i_cos   (w_cos),
        .i_kind  (r_kind),
        .i_alpha (r_alpha),
        .o_valid (w_cmb_v),
        .o_coef  (w_cmb_coef),
        .o_err   (w_cmb_err)
    );

    cwc_skid #(
        .COEF_W (COEF_W)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmb_v && w_en),
        .i_coef  (w_cmb_coef),
        .i_err   (w_cmb_err),
        .o_ready (w_en),
        .o_valid (w_out_v),
        .o_coef  (w_out_coef),
        .o_err   (w_out_err),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tvalid = w_out_v;
    assign m_axis_tdata  = TDATA_W'(w_out_coef);
    assign m_axis_tuser  = w_out_err;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> w_out_coef == '0)
        else $error("error word carries a nonzero coefficient");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(w_out_coef) <= $signed(COEF_ONE))
                       && ($signed(w_out_coef) >= -$signed(COEF_ONE)))
        else $error("coefficient outside plus or minus one");

    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser && (w_len == 13'd1) |-> w_out_coef == COEF_ONE)
        else $error("unit frame does not give one");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input blocked after reset");
`endif

endmodule

`default_nettype wire
